// ===== sv/quote_aware_csv_splitter_defines.svh =====
// ----------------------------------------------------------------------------
// quote_aware_csv_splitter_defines
// assertion macros for the csv splitter rtl
// ----------------------------------------------------------------------------
`ifndef QUOTE_AWARE_CSV_SPLITTER_DEFINES_SVH
`define QUOTE_AWARE_CSV_SPLITTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define QCSV_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qcsv assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define QCSV_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qcsv assertion failed");

`endif

// ===== sv/qcsv_pkg.sv =====
// ----------------------------------------------------------------------------
// qcsv_pkg
// types and constants of the quote aware csv splitter
// ----------------------------------------------------------------------------
package qcsv_pkg;

  localparam int unsigned MAX_FIELDS = 8;
  localparam int unsigned FIELD_W    = 3;
  localparam int unsigned COUNT_W    = 4;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [5:0] {
    PH_SKIP   = 6'b000001,
    PH_QUOTED = 6'b000010,
    PH_QPEND  = 6'b000100,
    PH_AFTER  = 6'b001000,
    PH_PLAIN  = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       end_of_line;
  } item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               byte_valid;
    logic               field_end;
    logic [FIELD_W-1:0] field_index;
    logic               line_done;
    logic [COUNT_W-1:0] field_count;
  } result_t;

  typedef struct packed {
    phase_t             phase;
    logic [FIELD_W-1:0] field;
  } status_t;

endpackage

// ===== sv/qcsv_in_reg.sv =====
// ----------------------------------------------------------------------------
// qcsv_in_reg
// input register stage of the csv splitter
// ----------------------------------------------------------------------------
module qcsv_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,
  input  logic            s_tlast,
  input  logic            advance,
  output logic            in_valid,
  output qcsv_pkg::item_t in_item
);

  // free slot, or the held request moves on this cycle
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.line_byte   <= s_tdata;
      in_item.end_of_line <= s_tlast;
    end
  end

endmodule

// ===== sv/qcsv_parser.sv =====
// ----------------------------------------------------------------------------
// qcsv_parser
// field state machine: one byte per step, at most one result
// ----------------------------------------------------------------------------
module qcsv_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  qcsv_pkg::item_t   in_item,
  output logic              res_valid,
  output qcsv_pkg::result_t res,
  output qcsv_pkg::status_t status
);

  qcsv_pkg::phase_t                   phase;
  qcsv_pkg::phase_t                   phase_next;
  logic [qcsv_pkg::FIELD_W-1:0]       field;
  logic [qcsv_pkg::FIELD_W-1:0]       field_next;
  logic [qcsv_pkg::COUNT_W-1:0]       cnt;
  logic [7:0]                         c;
  logic                               is_comma;
  logic                               is_quote;
  logic                               is_eolch;
  logic                               is_blank;
  logic                               do_comma;
  logic                               do_eline;
  logic                               do_content;

  assign c        = in_item.line_byte;
  assign is_comma = (c == qcsv_pkg::CH_COMMA);
  assign is_quote = (c == qcsv_pkg::CH_QUOTE);
  assign is_eolch = (c == qcsv_pkg::CH_CR) || (c == qcsv_pkg::CH_LF);
  assign is_blank = (c == qcsv_pkg::CH_SPACE) || (c == qcsv_pkg::CH_TAB);
  assign cnt      = {1'b0, field} + qcsv_pkg::COUNT_W'(1);

  always_comb begin
    phase_next = phase;
    field_next = field;
    do_comma   = 1'b0;
    do_eline   = 1'b0;
    do_content = 1'b0;

    if (in_item.end_of_line) begin
      do_eline = (phase != qcsv_pkg::PH_DONE);
    end else begin
      case (phase)
        qcsv_pkg::PH_SKIP: begin
          if (is_blank) begin
            phase_next = qcsv_pkg::PH_SKIP;
          end else if (is_quote) begin
            phase_next = qcsv_pkg::PH_QUOTED;
          end else if (is_comma) begin
            do_comma = 1'b1;
          end else if (is_eolch) begin
            do_eline = 1'b1;
          end else begin
            phase_next = qcsv_pkg::PH_PLAIN;
            do_content = 1'b1;
          end
        end
        qcsv_pkg::PH_PLAIN: begin
          if (is_comma) begin
            do_comma = 1'b1;
          end else if (is_eolch) begin
            do_eline = 1'b1;
          end else begin
            do_content = 1'b1;
          end
        end
        qcsv_pkg::PH_QUOTED: begin
          if (is_quote) begin
            phase_next = qcsv_pkg::PH_QPEND;
          end else begin
            do_content = 1'b1;
          end
        end
        qcsv_pkg::PH_QPEND: begin
          // doubled quote gives one quote, else the quote closed the field
          if (is_quote) begin
            phase_next = qcsv_pkg::PH_QUOTED;
            do_content = 1'b1;
          end else if (is_comma) begin
            do_comma = 1'b1;
          end else begin
            phase_next = qcsv_pkg::PH_AFTER;
          end
        end
        qcsv_pkg::PH_AFTER: begin
          if (is_comma) begin
            do_comma = 1'b1;
          end
        end
        default: begin
          phase_next = qcsv_pkg::PH_DONE;
        end
      endcase
    end

    res_valid       = do_comma || do_eline || do_content;
    res             = '0;
    res.field_index = field;

    if (do_content) begin
      res.out_byte   = c;
      res.byte_valid = 1'b1;
    end

    if (do_comma) begin
      res.field_end = 1'b1;
      if (cnt >= qcsv_pkg::COUNT_W'(qcsv_pkg::MAX_FIELDS)) begin
        res.line_done   = 1'b1;
        res.field_count = cnt;
        phase_next      = qcsv_pkg::PH_DONE;
      end else begin
        field_next = cnt[qcsv_pkg::FIELD_W-1:0];
        phase_next = qcsv_pkg::PH_SKIP;
      end
    end

    if (do_eline) begin
      res.field_end   = 1'b1;
      res.line_done   = 1'b1;
      res.field_count = cnt;
      phase_next      = qcsv_pkg::PH_DONE;
    end

    // terminator always rearms for the next line
    if (in_item.end_of_line) begin
      phase_next = qcsv_pkg::PH_SKIP;
      field_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= qcsv_pkg::PH_SKIP;
      field <= '0;
    end else if (advance) begin
      phase <= phase_next;
      field <= field_next;
    end
  end

  assign status.phase = phase;
  assign status.field = field;

endmodule

// ===== sv/qcsv_out_reg.sv =====
// ----------------------------------------------------------------------------
// qcsv_out_reg
// result register and master side of the csv splitter
// ----------------------------------------------------------------------------
module qcsv_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  qcsv_pkg::result_t res,
  output logic              out_free,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,
  output logic [1:0]        m_tuser,
  output logic              m_tlast
);

  qcsv_pkg::result_t held;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      held <= res;
    end
  end

  assign m_tdata = {1'b0, held.field_count, held.field_index, held.out_byte};
  assign m_tuser = {held.field_end, held.byte_valid};
  assign m_tlast = held.line_done;

endmodule

// ===== sv/quote_aware_csv_splitter.sv =====
// ----------------------------------------------------------------------------
// quote_aware_csv_splitter
// splits a text line into comma separated fields, quote aware
// ----------------------------------------------------------------------------
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   tdata = line byte, tlast = terminator
//   m_*      out  m_tvalid/m_tready   tdata = byte/index/count, tuser = flags,
//                                     tlast = line done
//
// one request per clock while the master side keeps up; a result passes the
// input register, then the parser state machine into the result reg
// requests that give no result leave the master side untouched
// rst is synchronous, active high: clears both valid flags and rearms the
// parser at the first field of a line
// a stalled master side backs up into the input register, then s_tready drops
// ----------------------------------------------------------------------------
`include "quote_aware_csv_splitter_defines.svh"

module quote_aware_csv_splitter (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] line_byte
  input  logic        s_tlast,   // end_of_line (string terminator item)
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] field_index,
                                 // [14:11] field_count, [15] zero
  output logic [1:0]  m_tuser,   // [0] byte_valid, [1] field_end
  output logic        m_tlast    // line_done
);

  logic              in_valid;
  qcsv_pkg::item_t   in_item;
  logic              res_valid;
  qcsv_pkg::result_t res;
  qcsv_pkg::status_t status;
  logic              out_free;
  logic              advance;

  // a request moves through the parser when its result, if any, has a slot
  assign advance = in_valid && (!res_valid || out_free);

  qcsv_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .advance  (advance),
    .in_valid (in_valid),
    .in_item  (in_item)
  );

  // field state machine: skip blanks, quoted, quote pending, after quote,
  // plain, line done
  qcsv_parser u_parse (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  qcsv_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res_valid),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // an accepted request lands in the input register
  `QCSV_ASSERT_NEXT(a_in_load, s_tvalid && s_tready, in_valid)
  // a result is never both a content byte and a field end
  `QCSV_ASSERT_IMP(a_flag_excl, m_tvalid, !(m_tuser[0] && m_tuser[1]))
  // line done always closes a field and reports a nonzero count
  `QCSV_ASSERT_IMP(a_done_ends, m_tvalid && m_tlast, m_tuser[1] && (m_tdata[14:11] != 4'd0))
  // a terminator rearms the parser at field zero
  `QCSV_ASSERT_NEXT(a_eol_rearm, advance && in_item.end_of_line,
                    (status.phase == qcsv_pkg::PH_SKIP) && (status.field == '0))

endmodule
